FILE: src/knn_pkg.sv
// shared constants for the k-nearest-neighbour search core
// store sizes, field widths and command codes; no dependencies
package knn_pkg;

	localparam int ENTRIES = 256;
	localparam int MAX_K   = 16;
	localparam int NFEAT   = 4;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int FEAT_W  = 16;
	localparam int DIST_W  = 18;
	localparam int QUO_W   = 16;

	// command codes carried in the input tuser
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic REG_NEIGHBOURS = 1'b0;
	localparam logic REG_FEATURES   = 1'b1;

	typedef logic [FEAT_W-1:0] feat_t;
	typedef logic [DIST_W-1:0] dist_t;

	// divider handshake between the core and each scale unit
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: src/knn_div.sv
// restoring divider, one quotient bit per cycle, for feature scaling
// uses knn_pkg; quotient must fit QUO_W bits (dividend high half < divisor)
module knn_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [2*knn_pkg::FEAT_W-1:0]      dividend,
	input  logic [knn_pkg::FEAT_W-1:0]        divisor,
	output logic [knn_pkg::QUO_W-1:0]         quotient,
	output knn_pkg::div_stat_t                stat
);

	localparam int CW = $clog2(knn_pkg::QUO_W + 1);

	logic [knn_pkg::FEAT_W-1:0] rem_q;
	logic [knn_pkg::FEAT_W-1:0] low_q;
	logic [knn_pkg::FEAT_W-1:0] div_q;
	logic [knn_pkg::QUO_W-1:0]  quo_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [knn_pkg::FEAT_W:0]   trial;
	logic                       fits;

	// one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, low_q[knn_pkg::FEAT_W-1]};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(knn_pkg::QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[2*knn_pkg::FEAT_W-1:knn_pkg::FEAT_W];
			low_q <= dividend[knn_pkg::FEAT_W-1:0];
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? knn_pkg::FEAT_W'(trial - {1'b0, div_q})
				: trial[knn_pkg::FEAT_W-1:0];
			low_q <= {low_q[knn_pkg::FEAT_W-2:0], 1'b0};
			quo_q <= {quo_q[knn_pkg::QUO_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: src/k_nearest_neighbour_search_core.sv
// k-nearest-neighbour search core: entry store, scaling pass and selection scans
// uses knn_pkg and four knn_div scale units
//
// channel  dir  beat contents
// s_*      in   tuser cmd; tdata features a..d, class label
// m_*      out  tdata index, distance, class; tuser store_empty; tlast is_last
// apb      in   neighbours at 0x0, features_used at 0x4
//
// a query with n entries and k results runs a scaling pass over the n
// entries (four dividers at one bit a cycle), then k scans through the
// distance memory; an empty-store query returns one store_empty beat
// reset clears control state and the maxima
// a result waiting in the output register stalls only the next emission
module k_nearest_neighbour_search_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // feature_a, feature_b, feature_c, feature_d, class_label
	input  logic [1:0]  s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // entry_index, neighbour_distance, neighbour_class
	output logic        m_tuser,  // store_empty
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = knn_pkg::IDX_W;
	localparam int CW = knn_pkg::CNT_W;
	localparam int FW = knn_pkg::FEAT_W;
	localparam int NF = knn_pkg::NFEAT;
	localparam int DW = knn_pkg::DIST_W;
	localparam int RW = NF * FW + 1;
	localparam int KW = $clog2(knn_pkg::MAX_K + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_LD   = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;
	localparam logic [2:0] ST_SCAN = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0]              state_q;
	logic [4:0]              neigh_q;
	logic [2:0]              nfeat_q;
	logic [CW-1:0]           count_q;
	knn_pkg::feat_t          max_q [NF];
	knn_pkg::feat_t          qf_q  [NF];
	logic [2:0]              nf_q;
	logic [CW-1:0]           k_q;
	logic [CW-1:0]           e_q;
	logic [CW-1:0]           idx_q;
	logic                    empty_q;

	// memories; distance words carry a picked mark above the label
	logic [RW-1:0]           fmem [knn_pkg::ENTRIES];
	logic [DW+1:0]           dmem [knn_pkg::ENTRIES];
	logic [RW-1:0]           frd_q;
	logic [DW+1:0]           drd_q;

	logic                    vld_s1;
	logic [IW-1:0]           idx_s1;
	logic                    found_q;
	logic [IW-1:0]           best_idx_q;
	knn_pkg::dist_t          best_dist_q;
	logic                    best_cls_q;

	logic                    div_start;
	logic [2*FW-1:0]         dvd   [NF];
	logic [knn_pkg::QUO_W-1:0] quo [NF];
	knn_pkg::div_stat_t      dstat [NF];

	logic                    s_acc;
	logic                    cfg_wr;
	logic                    out_free;
	logic [KW-1:0]           k_cap;
	knn_pkg::dist_t          dsum;
	logic                    better;

	assign s_acc    = s_tvalid && s_tready;
	assign s_tready = state_q == ST_IDLE;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign out_free = !m_tvalid || m_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neigh_q <= 5'd15;
			nfeat_q <= 3'd4;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				knn_pkg::REG_NEIGHBOURS: neigh_q <= pwdata[4:0];
				knn_pkg::REG_FEATURES:   nfeat_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	assign prdata = paddr[2] ? {29'd0, nfeat_q} : {27'd0, neigh_q};

	// effective neighbour count before limiting to the fill level
	always_comb begin
		if (neigh_q == 5'd0)
			k_cap = KW'(1);
		else if ({1'b0, neigh_q} > 6'(knn_pkg::MAX_K))
			k_cap = KW'(knn_pkg::MAX_K);
		else
			k_cap = KW'(neigh_q);
	end

	// scale units: x * 65472 taken as x * 65536 - x * 64
	always_comb begin
		for (int j = 0; j < NF; j++) begin
			dvd[j] = {frd_q[j*FW +: FW], 16'd0} - {10'd0, frd_q[j*FW +: FW], 6'd0};
		end
	end

	for (genvar g = 0; g < NF; g++) begin : g_div
		knn_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.dividend (dvd[g]),
			.divisor  (max_q[g]),
			.quotient (quo[g]),
			.stat     (dstat[g])
		);
	end

	assign div_start = state_q == ST_LD;

	// L1 distance over the leading features
	always_comb begin
		logic [FW-1:0] s;
		logic [FW-1:0] df;
		dsum = '0;
		for (int j = 0; j < NF; j++) begin
			s  = (max_q[j] == '0) ? '0 : quo[j];
			df = (s > qf_q[j]) ? s - qf_q[j] : qf_q[j] - s;
			if (3'(j) < nf_q)
				dsum = dsum + DW'(df);
		end
	end

	assign better = vld_s1 && !drd_q[DW+1] &&
		(!found_q || drd_q[DW-1:0] < best_dist_q);

	// feature memory
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == knn_pkg::CMD_LOAD && count_q < CW'(knn_pkg::ENTRIES))
			fmem[count_q[IW-1:0]] <= s_tdata[RW-1:0];
		if (state_q == ST_RD)
			frd_q <= fmem[idx_q[IW-1:0]];
	end

	// distance memory, label kept beside the distance, pick marked on emission
	always_ff @(posedge clk) begin
		if (state_q == ST_WR)
			dmem[idx_q[IW-1:0]] <= {1'b0, frd_q[RW-1], dsum};
		else if (state_q == ST_EMIT && out_free && !empty_q)
			dmem[best_idx_q] <= {1'b1, best_cls_q, best_dist_q};
		if (state_q == ST_SCAN && idx_q < count_q)
			drd_q <= dmem[idx_q[IW-1:0]];
	end

	// query operands
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == knn_pkg::CMD_QUERY) begin
			for (int j = 0; j < NF; j++)
				qf_q[j] <= s_tdata[j*FW +: FW];
			if (nfeat_q == 3'd0)
				nf_q <= 3'd1;
			else if (nfeat_q > 3'(NF))
				nf_q <= 3'(NF);
			else
				nf_q <= nfeat_q;
			k_q <= (CW'(k_cap) > count_q) ? count_q : CW'(k_cap);
		end
	end

	// scan candidate tracking
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q     <= 1'b1;
			best_idx_q  <= idx_s1;
			best_dist_q <= drd_q[DW-1:0];
			best_cls_q  <= drd_q[DW];
		end
		if (state_q == ST_WR && idx_q + 1'b1 == count_q)
			found_q <= 1'b0;
		idx_s1 <= idx_q[IW-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			for (int j = 0; j < NF; j++)
				max_q[j] <= '0;
			idx_q    <= '0;
			e_q      <= '0;
			empty_q  <= 1'b0;
			vld_s1   <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= 1'b0;
			m_tlast  <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						unique case (s_tuser)
							knn_pkg::CMD_LOAD: begin
								if (count_q < CW'(knn_pkg::ENTRIES)) begin
									count_q <= count_q + 1'b1;
									for (int j = 0; j < NF; j++)
										if (s_tdata[j*FW +: FW] > max_q[j])
											max_q[j] <= s_tdata[j*FW +: FW];
								end
							end
							knn_pkg::CMD_CLEAR: begin
								count_q <= '0;
								for (int j = 0; j < NF; j++)
									max_q[j] <= '0;
							end
							knn_pkg::CMD_QUERY: begin
								e_q      <= '0;
								idx_q    <= '0;
								empty_q  <= count_q == '0;
								state_q  <= (count_q == '0) ? ST_EMIT : ST_RD;
							end
							default: ;
						endcase
					end
				end
				ST_RD:  state_q <= ST_LD;
				ST_LD:  state_q <= ST_DIV;
				ST_DIV: if (dstat[0].done) state_q <= ST_WR;
				ST_WR: begin
					if (idx_q + 1'b1 == count_q) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_SCAN: begin
					if (idx_q < count_q) begin
						vld_s1 <= 1'b1;
						idx_q  <= idx_q + 1'b1;
					end else if (!vld_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						if (empty_q) begin
							m_tdata <= '0;
							m_tuser <= 1'b1;
							m_tlast <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							m_tdata <= {5'd0, best_cls_q, best_dist_q, 8'(best_idx_q)};
							m_tuser <= 1'b0;
							m_tlast <= e_q + 1'b1 == k_q;
							e_q     <= e_q + 1'b1;
							idx_q   <= '0;
							state_q <= (e_q + 1'b1 == k_q) ? ST_IDLE : ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// input is only taken between queries
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == ST_IDLE)
		else $error("input taken while busy");

	// fill level never passes the store depth
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(knn_pkg::ENTRIES))
		else $error("entry count overflow");

	// never more results than requested in one query
	a_pick_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> e_q < k_q)
		else $error("scan past requested neighbours");

	// a stalled result beat holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result beat changed while stalled");
`endif

endmodule
